[rtl/swc_pkg.sv]
package swc_pkg;

  localparam int PRICE_BITS = 32;
  localparam int SUM_BITS = PRICE_BITS + 1;
  localparam int CFG_BITS = 7;
  localparam int CODE_BITS = 3;
  localparam int WINDOW_MAX_DEFAULT = 64;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd20;

  localparam logic [CODE_BITS-1:0] POS_NEUTRAL = 3'd0;
  localparam logic [CODE_BITS-1:0] POS_UPPER_BREAK = 3'd1;
  localparam logic [CODE_BITS-1:0] POS_LOWER_BREAK = 3'd2;
  localparam logic [CODE_BITS-1:0] POS_UPPER_HALF = 3'd3;
  localparam logic [CODE_BITS-1:0] POS_LOWER_HALF = 3'd4;
  localparam logic [CODE_BITS-1:0] POS_MIDDLE = 3'd5;

  typedef struct packed {
    logic [PRICE_BITS-1:0] high_price;
    logic [PRICE_BITS-1:0] low_price;
    logic [PRICE_BITS-1:0] close_price;
  } bar_t;

  typedef struct packed {
    logic                  channel_valid;
    logic [PRICE_BITS-1:0] upper_band;
    logic [SUM_BITS-1:0]   middle_half_ticks;
    logic [PRICE_BITS-1:0] lower_band;
    logic [CODE_BITS-1:0]  position_code;
  } result_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] high;
    logic [PRICE_BITS-1:0] low;
  } cell_bar_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic init;
    logic take;
    logic sum;
  } red_ctrl_t;

endpackage

[rtl/sliding_window_channel.sv]
// Channel   Signals                                   Payload
// bar       bar_valid, bar_stall, bar                 swc_pkg::bar_t
// result    result_valid, result_stall, result        swc_pkg::result_t
// config    cfg_write_en, cfg_write_data              window_length
//
// For each request the history ring rotates once past the single max/min unit
// at its head, then state S_SUM forms the sum and S_EMIT loads the result
// register. rst is synchronous; it clears the fill count, control state and
// window_length (to 20). bar_stall is high while a request is in work; a
// stalled result holds the block in its last cycle.
module sliding_window_channel #(
  parameter int WINDOW_MAX = swc_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          bar_valid,
  output logic                          bar_stall,
  input  swc_pkg::bar_t                 bar,
  output logic                          result_valid,
  input  logic                          result_stall,
  output swc_pkg::result_t              result,
  input  logic                          cfg_write_en,
  input  logic [swc_pkg::CFG_BITS-1:0]  cfg_write_data
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EXT_W = (CNT_W > swc_pkg::CFG_BITS) ? CNT_W : swc_pkg::CFG_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_MAX - 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(WINDOW_MAX);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SUM = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                        state;
  logic [IDX_W-1:0]                  idx;
  logic [CNT_W-1:0]                  fill;
  logic [CNT_W-1:0]                  fill_next;
  logic [swc_pkg::CFG_BITS-1:0]      window_length;
  logic [CNT_W-1:0]                  win;
  logic [EXT_W-1:0]                  win_ext;
  logic                              full;
  logic [swc_pkg::PRICE_BITS-1:0]    close;
  logic                              bar_take;
  logic                              emit;

  swc_pkg::cell_ctrl_t               cell_ctrl;
  swc_pkg::red_ctrl_t                red_ctrl;
  swc_pkg::cell_bar_t                new_bar;
  swc_pkg::cell_bar_t                ring [WINDOW_MAX];

  logic [swc_pkg::PRICE_BITS-1:0]    upper;
  logic [swc_pkg::PRICE_BITS-1:0]    lower;
  logic [swc_pkg::SUM_BITS-1:0]      sum;
  logic [swc_pkg::CODE_BITS-1:0]     code;

  // clamp the window length to 1..WINDOW_MAX
  always_comb begin
    win_ext = EXT_W'(window_length);
    if (win_ext == '0) begin
      win_ext = EXT_W'(1);
    end else if (win_ext > EXT_W'(WINDOW_MAX)) begin
      win_ext = EXT_W'(WINDOW_MAX);
    end
    win = win_ext[CNT_W-1:0];
  end

  assign fill_next = (fill < FILL_MAX) ? fill + CNT_W'(1) : fill;

  assign bar_stall = (state != S_IDLE);
  assign bar_take = bar_valid && !bar_stall;
  assign emit = (state == S_EMIT) && (!result_valid || !result_stall);

  assign cell_ctrl.shift = bar_take;
  assign cell_ctrl.rotate = (state == S_SCAN);

  assign red_ctrl.init = (state == S_SCAN) && (idx == '0);
  assign red_ctrl.take = (state == S_SCAN) && (CNT_W'(idx) < win);
  assign red_ctrl.sum = (state == S_SUM);

  assign new_bar.high = bar.high_price;
  assign new_bar.low = bar.low_price;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      fill <= '0;
      full <= 1'b0;
      window_length <= swc_pkg::WINDOW_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        window_length <= cfg_write_data;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (bar_take) begin
            fill <= fill_next;
            full <= (fill_next >= win);
            idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx <= idx + IDX_W'(1);
          if (idx == LAST_IDX) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (bar_take) begin
      close <= bar.close_price;
    end
    if (emit) begin
      result.channel_valid <= full;
      result.upper_band <= full ? upper : '0;
      result.middle_half_ticks <= full ? sum : '0;
      result.lower_band <= full ? lower : '0;
      result.position_code <= full ? code : swc_pkg::POS_NEUTRAL;
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swc_pkg::cell_bar_t prev_bar;
    swc_pkg::cell_bar_t next_bar;

    if (i == 0) begin : g_head
      assign prev_bar = new_bar;
    end else begin : g_body
      assign prev_bar = ring[i-1];
    end

    // the last cell wraps back to the head while scanning
    if (i == WINDOW_MAX - 1) begin : g_tail
      assign next_bar = ring[0];
    end else begin : g_link
      assign next_bar = ring[i+1];
    end

    swc_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .prev_bar (prev_bar),
      .next_bar (next_bar),
      .bar      (ring[i])
    );
  end

  swc_reduce u_reduce (
    .clk   (clk),
    .ctrl  (red_ctrl),
    .bar   (ring[0]),
    .close (close),
    .upper (upper),
    .lower (lower),
    .sum   (sum),
    .code  (code)
  );

endmodule

[rtl/swc_cell.sv]
module swc_cell (
  input  logic               clk,
  input  swc_pkg::cell_ctrl_t ctrl,
  input  swc_pkg::cell_bar_t prev_bar,
  input  swc_pkg::cell_bar_t next_bar,
  output swc_pkg::cell_bar_t bar
);

  // shift toward older entries on a new request, rotate toward the head while scanning
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      bar <= prev_bar;
    end else if (ctrl.rotate) begin
      bar <= next_bar;
    end
  end

endmodule

[rtl/swc_reduce.sv]
module swc_reduce (
  input  logic                                 clk,
  input  swc_pkg::red_ctrl_t                   ctrl,
  input  swc_pkg::cell_bar_t                   bar,
  input  logic [swc_pkg::PRICE_BITS-1:0]       close,
  output logic [swc_pkg::PRICE_BITS-1:0]       upper,
  output logic [swc_pkg::PRICE_BITS-1:0]       lower,
  output logic [swc_pkg::SUM_BITS-1:0]         sum,
  output logic [swc_pkg::CODE_BITS-1:0]        code
);

  logic [swc_pkg::SUM_BITS-1:0] twice_close;

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      upper <= bar.high;
      lower <= bar.low;
    end else if (ctrl.take) begin
      if (bar.high > upper) begin
        upper <= bar.high;
      end
      if (bar.low < lower) begin
        lower <= bar.low;
      end
    end
    if (ctrl.sum) begin
      sum <= {1'b0, upper} + {1'b0, lower};
    end
  end

  assign twice_close = {close, 1'b0};

  // tests in priority order: breaks first, then the half against the middle line
  always_comb begin
    if (close >= upper) begin
      code = swc_pkg::POS_UPPER_BREAK;
    end else if (close <= lower) begin
      code = swc_pkg::POS_LOWER_BREAK;
    end else if (twice_close > sum) begin
      code = swc_pkg::POS_UPPER_HALF;
    end else if (twice_close < sum) begin
      code = swc_pkg::POS_LOWER_HALF;
    end else begin
      code = swc_pkg::POS_MIDDLE;
    end
  end

endmodule
